// ===== hw/rtl/estc_pkg.sv =====
// Package for the epoch seconds to calendar unit.
// Holds controller states, datapath phases, command/status structs and calendar constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package estc_pkg;

    localparam int REM_W = 33;

    typedef enum logic [2:0] {
        S_IDLE,
        S_YEAR,
        S_MONTH,
        S_DAY,
        S_HOUR,
        S_MIN,
        S_HOLD
    } state_t;

    typedef enum logic [2:0] {
        PH_YEAR,
        PH_MONTH,
        PH_DAY,
        PH_HOUR,
        PH_MIN
    } phase_t;

    typedef struct packed {
        logic   load;
        logic   step;
        logic   capture;
        phase_t phase;
    } cmd_t;

    typedef struct packed {
        logic less;
        logic mon_last;
    } status_t;

    localparam logic [REM_W-1:0] SECS_LEAP_YEAR   = 33'd31622400;
    localparam logic [REM_W-1:0] SECS_COMMON_YEAR = 33'd31536000;
    localparam logic [REM_W-1:0] SECS_PER_DAY     = 33'd86400;
    localparam logic [REM_W-1:0] SECS_PER_HOUR    = 33'd3600;
    localparam logic [REM_W-1:0] SECS_PER_MIN     = 33'd60;

    localparam logic [21:0] SECS_31_DAYS = 22'd2678400;
    localparam logic [21:0] SECS_30_DAYS = 22'd2592000;
    localparam logic [21:0] SECS_29_DAYS = 22'd2505600;
    localparam logic [21:0] SECS_28_DAYS = 22'd2419200;

    localparam logic [11:0] EPOCH_YEAR  = 12'd1970;
    // 1970 mod 4, mod 100, mod 400
    localparam logic [1:0]  MOD4_INIT   = 2'd2;
    localparam logic [6:0]  MOD100_INIT = 7'd70;
    localparam logic [8:0]  MOD400_INIT = 9'd370;
    localparam logic [6:0]  MOD100_LAST = 7'd99;
    localparam logic [8:0]  MOD400_LAST = 9'd399;

    localparam logic [3:0]  MONTH_FEB   = 4'd1;
    localparam logic [3:0]  MONTH_LAST  = 4'd11;

    // Month length in seconds, month index from 0
    function automatic logic [21:0] month_secs(input logic [3:0] mon, input logic leap);
        logic [21:0] secs;
        unique case (mon) inside
            4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: secs = SECS_31_DAYS;
            4'd3, 4'd5, 4'd8, 4'd10:                    secs = SECS_30_DAYS;
            MONTH_FEB:                                  secs = leap ? SECS_29_DAYS
                                                                    : SECS_28_DAYS;
            default:                                    secs = SECS_31_DAYS;
        endcase
        return secs;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/estc_intf.sv =====
// Valid/ready channel interfaces of the epoch seconds to calendar unit.
// Request, result and configuration channels; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface estc_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface estc_rsp_if;
    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    modport source (output valid, output year, output month, output day, output hour,
                    output minute, output second, input ready);
    modport sink   (input valid, input year, input month, input day, input hour,
                    input minute, input second, output ready);
endinterface

interface estc_cfg_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] zone_offset_seconds;

    modport source (output valid, output zone_offset_seconds, input ready);
    modport sink   (input valid, input zone_offset_seconds, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/estc_datapath.sv =====
// Datapath: zone offset register, remainder register with one shared
// subtract/compare unit, year/month/day/hour/minute counters, result register.
// Depends on estc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module estc_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic signed [17:0] cfg_data,
    input  wire logic [31:0]        epoch_seconds,
    input  wire estc_pkg::cmd_t     cmd,
    output estc_pkg::status_t       status,
    output logic [11:0]             year,
    output logic [3:0]              month,
    output logic [4:0]              day,
    output logic [4:0]              hour,
    output logic [5:0]              minute,
    output logic [5:0]              second
);
    import estc_pkg::*;

    logic signed [17:0] zone_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [11:0]        year_reg;
    logic [1:0]         mod4_reg;
    logic [6:0]         mod100_reg;
    logic [8:0]         mod400_reg;
    logic [3:0]         mon_reg;
    logic [4:0]         day_reg;
    logic [4:0]         hour_reg;
    logic [5:0]         min_reg;

    logic [11:0]        year_out_reg;
    logic [3:0]         month_out_reg;
    logic [4:0]         day_out_reg;
    logic [4:0]         hour_out_reg;
    logic [5:0]         min_out_reg;
    logic [5:0]         sec_out_reg;

    logic [REM_W:0]     local_sum;
    logic [REM_W-1:0]   local_clamped;
    logic [REM_W-1:0]   sub;
    logic               leap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= '0;
        end
        else if (cfg_we)
        begin
            zone_reg <= cfg_data;
        end
    end

    // 34-bit signed sum; top bit set means negative local time
    assign local_sum     = {2'b00, epoch_seconds} + {{16{zone_reg[17]}}, zone_reg};
    assign local_clamped = local_sum[REM_W] ? '0 : local_sum[REM_W-1:0];

    assign leap = ((mod4_reg == 2'd0) && (mod100_reg != 7'd0)) || (mod400_reg == 9'd0);

    always_comb
    begin
        case (cmd.phase)
            PH_YEAR:  sub = leap ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
            PH_MONTH: sub = {11'd0, month_secs(mon_reg, leap)};
            PH_DAY:   sub = SECS_PER_DAY;
            PH_HOUR:  sub = SECS_PER_HOUR;
            default:  sub = SECS_PER_MIN;
        endcase
    end

    assign status.less     = rem_reg < sub;
    assign status.mon_last = mon_reg == MONTH_LAST;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg    <= local_clamped;
            year_reg   <= EPOCH_YEAR;
            mod4_reg   <= MOD4_INIT;
            mod100_reg <= MOD100_INIT;
            mod400_reg <= MOD400_INIT;
            mon_reg    <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            min_reg    <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_reg - sub;
            case (cmd.phase)
                PH_YEAR:
                begin
                    year_reg   <= year_reg + 12'd1;
                    mod4_reg   <= mod4_reg + 2'd1;
                    mod100_reg <= (mod100_reg == MOD100_LAST) ? 7'd0 : mod100_reg + 7'd1;
                    mod400_reg <= (mod400_reg == MOD400_LAST) ? 9'd0 : mod400_reg + 9'd1;
                end
                PH_MONTH: mon_reg  <= mon_reg + 4'd1;
                PH_DAY:   day_reg  <= day_reg + 5'd1;
                PH_HOUR:  hour_reg <= hour_reg + 5'd1;
                default:  min_reg  <= min_reg + 6'd1;
            endcase
        end
    end

    // result register: holds while the result waits downstream
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            year_out_reg  <= year_reg;
            month_out_reg <= mon_reg + 4'd1;
            day_out_reg   <= day_reg + 5'd1;
            hour_out_reg  <= hour_reg;
            min_out_reg   <= min_reg;
            sec_out_reg   <= rem_reg[5:0];
        end
    end

    assign year   = year_out_reg;
    assign month  = month_out_reg;
    assign day    = day_out_reg;
    assign hour   = hour_out_reg;
    assign minute = min_out_reg;
    assign second = sec_out_reg;

    a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (rem_reg < SECS_PER_MIN))
        else $error("remainder not below one minute at capture");

    a_step_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> (rem_reg < $past(rem_reg)))
        else $error("step did not reduce remainder");

    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> ((mon_reg <= MONTH_LAST) && (hour_reg <= 5'd23) && (min_reg <= 6'd59)))
        else $error("calendar field out of range at capture");

endmodule

`default_nettype wire

// ===== hw/rtl/estc_ctrl.sv =====
// Controller: sequences load, year/month/day/hour/minute subtraction phases
// and result capture; owns the result valid flag. Depends on estc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module estc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    input  wire estc_pkg::status_t status,
    output estc_pkg::cmd_t         cmd
);
    import estc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        req_ready   = 1'b0;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.capture = 1'b0;
        cmd.phase   = PH_MIN;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_YEAR;
                end
            end
            S_YEAR:
            begin
                cmd.phase = PH_YEAR;
                if (status.less) state_next = S_MONTH;
                else             cmd.step   = 1'b1;
            end
            S_MONTH:
            begin
                cmd.phase = PH_MONTH;
                if (status.less || status.mon_last) state_next = S_DAY;
                else                                cmd.step   = 1'b1;
            end
            S_DAY:
            begin
                cmd.phase = PH_DAY;
                if (status.less) state_next = S_HOUR;
                else             cmd.step   = 1'b1;
            end
            S_HOUR:
            begin
                cmd.phase = PH_HOUR;
                if (status.less) state_next = S_MIN;
                else             cmd.step   = 1'b1;
            end
            S_MIN:
            begin
                cmd.phase = PH_MIN;
                if (status.less) state_next = S_HOLD;
                else             cmd.step   = 1'b1;
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cmd.capture)                rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && rsp_ready) rsp_valid_next = 1'b0;
        else                            rsp_valid_next = rsp_valid_reg;
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/epoch_seconds_to_calendar_unit.sv =====
// The remainder is reduced step by step: whole years (up to 136), whole months (up to 11), days
// (up to 30), hours (up to 23) and minutes (up to 59), by the one subtract/compare unit that
// takes one step per cycle.
// A new request is taken while the result register waits, and a finished result holds the
// controller until that register frees.
// Reset (rst_n, async, active low): controller idle, no result pending, zone offset zero.
// Top level of the epoch seconds to calendar unit; uses estc_pkg, estc_intf, estc_ctrl,
// estc_datapath.
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_calendar_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    estc_req_if.sink   request,
    estc_rsp_if.source result,
    estc_cfg_if.sink   cfg
);
    import estc_pkg::*;

    cmd_t    cmd;
    status_t status;

    // The zone offset write never stalls; the user must write only while idle, the block does not enforce it.
    assign cfg.ready = 1'b1;

    // Controller: walks the phases year -> month -> day -> hour -> minute,
    // one subtraction per cycle, then captures into the result register.
    estc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .rsp_valid (result.valid),
        .rsp_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: local time = epoch + offset, clamped at zero; the remainder is
    // reduced by year, month, day, hour and minute lengths; what is left is seconds.
    estc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg.valid),
        .cfg_data      (cfg.zone_offset_seconds),
        .epoch_seconds (request.epoch_seconds),
        .cmd           (cmd),
        .status        (status),
        .year          (result.year),
        .month         (result.month),
        .day           (result.day),
        .hour          (result.hour),
        .minute        (result.minute),
        .second        (result.second)
    );

endmodule

`default_nettype wire
